// ===== hw/rtl/ddq_pkg.sv =====
// ----------------------------------------------------------------------------
// ddq_pkg - shared types and constants for the deduplicating key queue
// Opcodes, status codes, cell commands and the structs that travel between
// the queue cells, the journal cells and the control logic.
// ----------------------------------------------------------------------------
package ddq_pkg;

    localparam int KEY_W         = 64;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;
    localparam int KIND_W        = 2;
    localparam int OUT_CNT_W     = 5;
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_JOURNAL_DEPTH = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_UNDO = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOT_REG = 3'd1,
        ST_DUP     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4,
        ST_NO_UNDO = 3'd5
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        UNDO_NONE = 2'd0,
        UNDO_ENQ  = 2'd1,
        UNDO_DEQ  = 2'd2
    } undone_t;

    typedef enum logic {
        JK_ENQ = 1'b0,
        JK_DEQ = 1'b1
    } jkind_t;

    // Queue cell commands: hold, load the broadcast key, shift toward the
    // head (dequeue) or shift toward the tail (reinsert at the head).
    typedef enum logic [1:0] {
        Q_HOLD = 2'd0,
        Q_LOAD = 2'd1,
        Q_SHL  = 2'd2,
        Q_SHR  = 2'd3
    } qcmd_t;

    typedef enum logic [1:0] {
        J_HOLD = 2'd0,
        J_PUSH = 2'd1,
        J_POP  = 2'd2
    } jcmd_t;

    typedef struct packed {
        qcmd_t cmd;
        logic  valid;
        logic  tail;
    } qctl_t;

    // Token that walks down the queue cells, collecting a duplicate hit and
    // picking up the tail key on its way.
    typedef struct packed {
        logic             tok;
        logic             hit;
        logic [KEY_W-1:0] key;
    } scan_t;

    typedef struct packed {
        jkind_t           kind;
        logic [KEY_W-1:0] key;
    } jent_t;

endpackage

// ===== hw/rtl/ddq_qcell.sv =====
// ----------------------------------------------------------------------------
// ddq_qcell - one queue position
// Holds the key at one position counted from the head and forwards the
// scan token to the next position each cycle.
// ----------------------------------------------------------------------------
module ddq_qcell
    import ddq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  qctl_t            ctl,
    input  logic [KEY_W-1:0] load_key,
    input  logic [KEY_W-1:0] left_key,
    input  logic [KEY_W-1:0] right_key,
    input  logic [KEY_W-1:0] probe_key,
    input  scan_t            scan_in,
    output logic [KEY_W-1:0] key,
    output scan_t            scan_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    scan_t            scan_reg;
    scan_t            scan_next;

    always_comb begin
        case (ctl.cmd)
            Q_LOAD:  key_next = load_key;
            Q_SHL:   key_next = right_key;
            Q_SHR:   key_next = left_key;
            default: key_next = key_reg;
        endcase
    end

    always_comb begin
        scan_next.tok = scan_in.tok;
        scan_next.hit = scan_in.hit
                      | (scan_in.tok & ctl.valid & (key_reg == probe_key));
        scan_next.key = (scan_in.tok & ctl.tail) ? key_reg : scan_in.key;
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        scan_reg.hit <= scan_next.hit;
        scan_reg.key <= scan_next.key;
        if (!aresetn) begin
            scan_reg.tok <= 1'b0;
        end else begin
            scan_reg.tok <= scan_next.tok;
        end
    end

    assign key      = key_reg;
    assign scan_out = scan_reg;

endmodule

// ===== hw/rtl/ddq_jcell.sv =====
// ----------------------------------------------------------------------------
// ddq_jcell - one journal stack position
// Holds one logged action; a push moves entries away from the top, a pop
// moves them toward it.
// ----------------------------------------------------------------------------
module ddq_jcell
    import ddq_pkg::*;
(
    input  logic  aclk,
    input  jcmd_t cmd,
    input  jent_t left_ent,
    input  jent_t right_ent,
    output jent_t ent
);

    jent_t ent_reg;
    jent_t ent_next;

    always_comb begin
        case (cmd)
            J_PUSH:  ent_next = left_ent;
            J_POP:   ent_next = right_ent;
            default: ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// ===== hw/rtl/dedup_queue_with_undo_log_core.sv =====
// ----------------------------------------------------------------------------
// dedup_queue_with_undo_log_core - deduplicating key queue with undo journal
// A FIFO of keys that rejects duplicates and logs every change so that it
// can be undone, built from a row of queue cells and a row of journal cells.
// ----------------------------------------------------------------------------
// Usage: each s_ transaction carries one command (enqueue, dequeue, undo)
// and produces exactly one m_ transaction with the status, the key that
// was moved, the kind of undo performed and both occupancy counts.
// The queue is a row of QUEUE_DEPTH cells ordered from the head; the
// journal is a row of JOURNAL_DEPTH cells ordered from the newest entry.
// Enqueue and undo send a token down the queue cells, one cell per cycle,
// to check for a duplicate key and to fetch the tail key before their
// result is registered; a dequeue and the unused opcode skip the scan and
// go straight to the final step. s_ready returns the cycle after the
// result is registered, so the block takes no new command before the
// result of the last one is in the output register.
// s_ready is high whenever the control is idle, also while a finished
// result still waits in the output register. If the receiver stalls, the
// next command runs up to its final step and waits there until the
// output register is free. Reset empties the queue and the journal;
// key storage is not cleared and is only read below the fill counts.
// ----------------------------------------------------------------------------
module dedup_queue_with_undo_log_core
    import ddq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int JOURNAL_DEPTH = DEF_JOURNAL_DEPTH
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_op,
    input  logic [KEY_W-1:0]     s_patient_key,
    input  logic                 s_registered,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [KEY_W-1:0]     m_result_key,
    output logic [KIND_W-1:0]    m_undone_kind,
    output logic [OUT_CNT_W-1:0] m_queue_count,
    output logic [OUT_CNT_W-1:0] m_journal_count
);

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int JCNT_W = $clog2(JOURNAL_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                registered_reg;
    logic                start_reg;
    logic                dup_reg;
    logic [KEY_W-1:0]    tail_key_reg;
    logic [QCNT_W-1:0]   qfill_reg;
    logic [JCNT_W-1:0]   jfill_reg;

    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [KEY_W-1:0]    m_result_key_reg;
    undone_t             m_undone_kind_reg;
    logic [OUT_CNT_W-1:0] m_queue_count_reg;
    logic [OUT_CNT_W-1:0] m_journal_count_reg;

    // Cell interconnect.
    logic [KEY_W-1:0] qkey [QUEUE_DEPTH];
    qctl_t            qctl [QUEUE_DEPTH];
    scan_t            scan [QUEUE_DEPTH+1];
    jent_t            jent [JOURNAL_DEPTH];

    // Step results.
    logic             out_free;
    logic             exec_fire;
    qcmd_t            q_op;
    jcmd_t            j_cmd;
    jent_t            j_push_ent;
    status_t          status_next;
    logic [KEY_W-1:0] rkey_next;
    undone_t          undone_next;
    logic [QCNT_W-1:0] qfill_next;
    logic [JCNT_W-1:0] jfill_next;
    logic             q_full;
    logic             j_full;

    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign q_full    = (qfill_reg == QCNT_W'(QUEUE_DEPTH));
    assign j_full    = (jfill_reg == JCNT_W'(JOURNAL_DEPTH));

    // The scan token enters the head cell in the cycle after the command is
    // taken and passes through every queue cell register to leave the last cell.
    assign scan[0] = '{tok: start_reg, hit: 1'b0, key: '0};

    always_comb begin
        q_op        = Q_HOLD;
        j_cmd       = J_HOLD;
        j_push_ent  = '{kind: JK_ENQ, key: key_reg};
        status_next = ST_OK;
        rkey_next   = '0;
        undone_next = UNDO_NONE;
        qfill_next  = qfill_reg;
        jfill_next  = j_full ? jfill_reg : jfill_reg + 1'b1;

        case (op_reg)
            OP_ENQ: begin
                if (!registered_reg) begin
                    status_next = ST_NOT_REG;
                end else if (dup_reg) begin
                    status_next = ST_DUP;
                end else if (q_full) begin
                    status_next = ST_FULL;
                end else begin
                    q_op       = Q_LOAD;
                    j_cmd      = J_PUSH;
                    qfill_next = qfill_reg + 1'b1;
                    rkey_next  = key_reg;
                end
            end
            OP_DEQ: begin
                if (qfill_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    q_op       = Q_SHL;
                    j_cmd      = J_PUSH;
                    j_push_ent = '{kind: JK_DEQ, key: qkey[0]};
                    qfill_next = qfill_reg - 1'b1;
                    rkey_next  = qkey[0];
                end
            end
            OP_UNDO: begin
                if (jfill_reg == '0) begin
                    status_next = ST_NO_UNDO;
                end else begin
                    // The newest journal entry is consumed in every case.
                    j_cmd = J_POP;
                    if (jent[0].kind == JK_ENQ) begin
                        if (qfill_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            qfill_next  = qfill_reg - 1'b1;
                            rkey_next   = tail_key_reg;
                            undone_next = UNDO_ENQ;
                        end
                    end else begin
                        if (q_full) begin
                            status_next = ST_FULL;
                        end else begin
                            q_op        = Q_SHR;
                            qfill_next  = qfill_reg + 1'b1;
                            rkey_next   = jent[0].key;
                            undone_next = UNDO_DEQ;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        case (j_cmd)
            J_PUSH:  begin end
            J_POP:   jfill_next = jfill_reg - 1'b1;
            default: jfill_next = jfill_reg;
        endcase

        if (!exec_fire) begin
            q_op  = Q_HOLD;
            j_cmd = J_HOLD;
        end
    end

    // Queue cells, position 0 is the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_qcell
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;
        logic             at_fill;

        assign at_fill = (QCNT_W'(i) == qfill_reg);

        if (i == 0) begin : g_first
            assign left_key = jent[0].key;
        end else begin : g_mid
            assign left_key = qkey[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_key = qkey[i];
        end else begin : g_inner
            assign right_key = qkey[i+1];
        end

        assign qctl[i].cmd   = (q_op == Q_LOAD && !at_fill) ? Q_HOLD : q_op;
        assign qctl[i].valid = (QCNT_W'(i) < qfill_reg);
        assign qctl[i].tail  = (QCNT_W'(i + 1) == qfill_reg);

        ddq_qcell u_qcell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (qctl[i]),
            .load_key  (key_reg),
            .left_key  (left_key),
            .right_key (right_key),
            .probe_key (key_reg),
            .scan_in   (scan[i]),
            .key       (qkey[i]),
            .scan_out  (scan[i+1])
        );
    end

    // Journal cells, position 0 is the newest entry. A push into a full
    // journal lets the oldest entry fall off the far end.
    for (genvar j = 0; j < JOURNAL_DEPTH; j++) begin : g_jcell
        jent_t left_ent;
        jent_t right_ent;

        if (j == 0) begin : g_first
            assign left_ent = j_push_ent;
        end else begin : g_mid
            assign left_ent = jent[j-1];
        end

        if (j == JOURNAL_DEPTH - 1) begin : g_last
            assign right_ent = jent[j];
        end else begin : g_inner
            assign right_ent = jent[j+1];
        end

        ddq_jcell u_jcell (
            .aclk      (aclk),
            .cmd       (j_cmd),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .ent       (jent[j])
        );
    end

    // Control and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            qfill_reg   <= '0;
            jfill_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A scan starts only for an accepted enqueue or undo.
            start_reg <= s_valid && s_ready
                         && (op_t'(s_op) == OP_ENQ || op_t'(s_op) == OP_UNDO);
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg         <= op_t'(s_op);
                        key_reg        <= s_patient_key;
                        registered_reg <= s_registered;
                        if (op_t'(s_op) == OP_ENQ || op_t'(s_op) == OP_UNDO) begin
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan[QUEUE_DEPTH].tok) begin
                        dup_reg      <= scan[QUEUE_DEPTH].hit;
                        tail_key_reg <= scan[QUEUE_DEPTH].key;
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_status_reg        <= status_next;
                        m_result_key_reg    <= rkey_next;
                        m_undone_kind_reg   <= undone_next;
                        m_queue_count_reg   <= OUT_CNT_W'(qfill_next);
                        m_journal_count_reg <= OUT_CNT_W'(jfill_next);
                        qfill_reg           <= qfill_next;
                        jfill_reg           <= jfill_next;
                        state_reg           <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_key    = m_result_key_reg;
    assign m_undone_kind   = m_undone_kind_reg;
    assign m_queue_count   = m_queue_count_reg;
    assign m_journal_count = m_journal_count_reg;

endmodule

// ===== dv/dedup_queue_with_undo_log_core_test.sv =====
// ----------------------------------------------------------------------------
// dedup_queue_with_undo_log_core_test - self-checking bench for the key queue
// Drives enqueue, dequeue, undo and the unused opcode through the s_ channel.
// Every m_ transaction is compared field by field against a hand-typed result
// (fixed directed rows) or a behavioral model of the queue and journal in the bench.
// ----------------------------------------------------------------------------
module dedup_queue_with_undo_log_core_test;
    import ddq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH   = DEF_QUEUE_DEPTH;
    localparam int JOURNAL_DEPTH = DEF_JOURNAL_DEPTH;

    // Hard stop for the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 600000;

    // Cycles the receiver refuses results during the backpressure phase.
    localparam int HOLD_OFF_CYCLES = 500;

    // Random transactions per traffic phase; six phases in total.
    localparam int PHASE_ITEMS = 300;
    localparam int PHASES      = 6;
    localparam int POOL_KEYS   = 12;

    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_A    = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] KEY_B    = 64'hFEDC_BA98_7654_3210;

    // One m_ transaction as the block should produce it.
    typedef struct packed {
        status_t               status;
        logic [KEY_W-1:0]      key;
        undone_t               undone;
        logic [OUT_CNT_W-1:0]  queue_count;
        logic [OUT_CNT_W-1:0]  journal_count;
    } reply_t;

    // One row of the directed table. Rows with fixed_reply set carry the
    // result typed in by hand; all others are checked against the model.
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic             registered;
        logic             fixed_reply;
        reply_t           reply;
    } command_row_t;

    typedef enum int {
        IDLE_OFF,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } traffic_mode_t;

    localparam reply_t NO_REPLY = '0;

    // The directed walk: reset-state errors, the unused opcode, the key
    // extremes, the not-registered and duplicate rejections of an enqueue,
    // dequeue and both undo kinds, ending with the journal drained back to empty.
    localparam int DIRECTED_ROWS = 24;
    localparam command_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{OP_DEQ,  KEY_ZERO, 1'b0, 1'b1, '{ST_EMPTY,   KEY_ZERO, UNDO_NONE, 5'd0, 5'd0}},
        '{OP_UNDO, KEY_ZERO, 1'b0, 1'b1, '{ST_NO_UNDO, KEY_ZERO, UNDO_NONE, 5'd0, 5'd0}},
        '{OP_NONE, KEY_ONES, 1'b1, 1'b1, '{ST_OK,      KEY_ZERO, UNDO_NONE, 5'd0, 5'd0}},
        '{OP_ENQ,  KEY_ONES, 1'b0, 1'b1, '{ST_NOT_REG, KEY_ZERO, UNDO_NONE, 5'd0, 5'd0}},
        '{OP_ENQ,  KEY_ONES, 1'b1, 1'b1, '{ST_OK,      KEY_ONES, UNDO_NONE, 5'd1, 5'd1}},
        '{OP_ENQ,  KEY_ONES, 1'b1, 1'b1, '{ST_DUP,     KEY_ZERO, UNDO_NONE, 5'd1, 5'd1}},
        '{OP_ENQ,  KEY_ZERO, 1'b0, 1'b1, '{ST_NOT_REG, KEY_ZERO, UNDO_NONE, 5'd1, 5'd1}},
        '{OP_ENQ,  KEY_ZERO, 1'b1, 1'b1, '{ST_OK,      KEY_ZERO, UNDO_NONE, 5'd2, 5'd2}},
        '{OP_ENQ,  KEY_A,    1'b1, 1'b0, NO_REPLY},
        '{OP_ENQ,  KEY_ZERO, 1'b1, 1'b1, '{ST_DUP,     KEY_ZERO, UNDO_NONE, 5'd3, 5'd3}},
        '{OP_DEQ,  KEY_B,    1'b1, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_B,    1'b0, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_ONES, 1'b1, 1'b0, NO_REPLY},
        '{OP_DEQ,  KEY_ZERO, 1'b0, 1'b0, NO_REPLY},
        '{OP_DEQ,  KEY_ONES, 1'b1, 1'b0, NO_REPLY},
        '{OP_DEQ,  KEY_ZERO, 1'b0, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_ZERO, 1'b0, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_ZERO, 1'b0, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_A,    1'b1, 1'b0, NO_REPLY},
        '{OP_ENQ,  KEY_B,    1'b1, 1'b0, NO_REPLY},
        '{OP_NONE, KEY_ZERO, 1'b0, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_ZERO, 1'b0, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_ZERO, 1'b0, 1'b0, NO_REPLY},
        '{OP_UNDO, KEY_ZERO, 1'b0, 1'b1, '{ST_NO_UNDO, KEY_ZERO, UNDO_NONE, 5'd0, 5'd0}}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op = OP_NONE;
    logic [KEY_W-1:0]     s_patient_key = '0;
    logic                 s_registered = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [KEY_W-1:0]     m_result_key;
    logic [KIND_W-1:0]    m_undone_kind;
    logic [OUT_CNT_W-1:0] m_queue_count;
    logic [OUT_CNT_W-1:0] m_journal_count;

    // Model state: the queued keys, head first, and the journal, oldest
    // entry first. The journal drops its oldest entry when it overflows.
    logic [KEY_W-1:0] model_queue[$];
    jent_t            model_journal[$];

    // Results still owed by the block, oldest first.
    reply_t pending_replies[$];

    traffic_mode_t traffic_mode = IDLE_OFF;
    int            mismatches = 0;
    int            cycle_count = 0;

    // The main process bumps hold_requests; the receiver process serves each
    // request with one long stretch of m_ready low.
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    dedup_queue_with_undo_log_core #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .JOURNAL_DEPTH (JOURNAL_DEPTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_patient_key   (s_patient_key),
        .s_registered    (s_registered),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_key    (m_result_key),
        .m_undone_kind   (m_undone_kind),
        .m_queue_count   (m_queue_count),
        .m_journal_count (m_journal_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_replies.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Appends a journal entry, dropping the oldest one when the journal is
    // already at its depth.
    function automatic void log_action(input jkind_t kind, input logic [KEY_W-1:0] key);
        jent_t entry;
        entry.kind = kind;
        entry.key = key;
        if (model_journal.size() >= JOURNAL_DEPTH)
            void'(model_journal.pop_front());
        model_journal.push_back(entry);
    endfunction

    // Applies one command to the model and returns the result it should
    // produce. Error results carry key zero and no undo kind.
    function automatic reply_t queue_step(input op_t op, input logic [KEY_W-1:0] key,
                                          input logic registered);
        reply_t reply;
        jent_t  entry;
        logic   queued;
        reply = NO_REPLY;
        reply.status = ST_OK;
        reply.undone = UNDO_NONE;
        queued = 1'b0;
        case (op)
            OP_ENQ: begin
                foreach (model_queue[i])
                    if (model_queue[i] == key)
                        queued = 1'b1;
                // Registration is checked first, then duplicates, then room.
                if (!registered) begin
                    reply.status = ST_NOT_REG;
                end else if (queued) begin
                    reply.status = ST_DUP;
                end else if (model_queue.size() >= QUEUE_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    model_queue.push_back(key);
                    log_action(JK_ENQ, key);
                    reply.key = key;
                end
            end
            OP_DEQ: begin
                if (model_queue.size() == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    reply.key = model_queue.pop_front();
                    log_action(JK_DEQ, reply.key);
                end
            end
            OP_UNDO: begin
                if (model_journal.size() == 0) begin
                    reply.status = ST_NO_UNDO;
                end else begin
                    // The entry is consumed even when the queue cannot take
                    // the reversal.
                    entry = model_journal.pop_back();
                    if (entry.kind == JK_ENQ) begin
                        if (model_queue.size() == 0) begin
                            reply.status = ST_EMPTY;
                        end else begin
                            reply.key = model_queue.pop_back();
                            reply.undone = UNDO_ENQ;
                        end
                    end else begin
                        // A restored key goes back to the head unchecked.
                        if (model_queue.size() >= QUEUE_DEPTH) begin
                            reply.status = ST_FULL;
                        end else begin
                            model_queue.push_front(entry.key);
                            reply.key = entry.key;
                            reply.undone = UNDO_DEQ;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        reply.queue_count = OUT_CNT_W'(model_queue.size());
        reply.journal_count = OUT_CNT_W'(model_journal.size());
        return reply;
    endfunction

    // Offers one command on the s_ channel and records what it should
    // produce once the transaction is taken. Called right after a rising
    // edge; returns right after the edge that accepted the transaction.
    task automatic send_command(input op_t op, input logic [KEY_W-1:0] key,
                                input logic registered, input logic fixed_reply,
                                input reply_t typed_reply);
        int     idle_pct;
        reply_t modeled;
        idle_pct = (traffic_mode == IDLE_SENDER) ? 61 :
                   (traffic_mode == IDLE_BOTH)   ? 20 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_patient_key <= key;
        s_registered <= registered;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        modeled = queue_step(op, key, registered);
        pending_replies.push_back(fixed_reply ? typed_reply : modeled);
    endtask

    // Result side: checks every accepted m_ transaction against the oldest
    // owed result, then decides m_ready for the next cycle. A pending hold
    // request overrides the random stalls with a stretch set by HOLD_OFF_CYCLES.
    always @(posedge aclk) begin
        reply_t owed;
        int     stall_pct;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d key %h",
                                          m_status, m_result_key));
            end else begin
                owed = pending_replies.pop_front();
                if (m_status !== owed.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_status, owed.status));
                if (m_result_key !== owed.key)
                    report_mismatch($sformatf("result_key %h, expected %h",
                                              m_result_key, owed.key));
                if (m_undone_kind !== owed.undone)
                    report_mismatch($sformatf("undone_kind %0d, expected %0d",
                                              m_undone_kind, owed.undone));
                if (m_queue_count !== owed.queue_count)
                    report_mismatch($sformatf("queue_count %0d, expected %0d",
                                              m_queue_count, owed.queue_count));
                if (m_journal_count !== owed.journal_count)
                    report_mismatch($sformatf("journal_count %0d, expected %0d",
                                              m_journal_count, owed.journal_count));
            end
        end
        if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES;
        end
        stall_pct = (traffic_mode == IDLE_RECEIVER) ? 61 :
                    (traffic_mode == IDLE_BOTH)     ? 20 : 0;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Main sequence: reset, the directed table, then random phases that
    // rotate through the idling patterns. Within a phase the mix of
    // operations changes every few dozen transactions between filling,
    // draining and undo-heavy traffic, so the queue and the journal both
    // reach full and empty. Keys come mostly from a small pool so that
    // duplicates are common, with fresh random keys mixed in.
    initial begin
        logic [KEY_W-1:0] key_pool[POOL_KEYS];
        logic [KEY_W-1:0] key;
        op_t              op;
        int               enq_pct;
        int               deq_pct;
        int               pick;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        traffic_mode = IDLE_OFF;
        for (int row = 0; row < DIRECTED_ROWS; row++)
            send_command(DIRECTED_TABLE[row].op, DIRECTED_TABLE[row].key,
                         DIRECTED_TABLE[row].registered,
                         DIRECTED_TABLE[row].fixed_reply, DIRECTED_TABLE[row].reply);

        enq_pct = 50;
        deq_pct = 25;
        for (int phase = 0; phase < PHASES; phase++) begin
            traffic_mode = traffic_mode_t'(phase % 4);
            foreach (key_pool[i])
                key_pool[i] = {$urandom, $urandom};
            // The backpressure phase runs without sender gaps, so the block
            // takes one more command, parks it and then drops s_ready.
            if (phase == 4)
                hold_requests++;
            for (int item = 0; item < PHASE_ITEMS; item++) begin
                if (item % 40 == 0) begin
                    case ($urandom_range(2))
                        0: begin enq_pct = 75; deq_pct = 15; end
                        1: begin enq_pct = 20; deq_pct = 65; end
                        default: begin enq_pct = 40; deq_pct = 20; end
                    endcase
                end
                pick = $urandom_range(99);
                if (pick < enq_pct)
                    op = OP_ENQ;
                else if (pick < enq_pct + deq_pct)
                    op = OP_DEQ;
                else if (pick < 98)
                    op = OP_UNDO;
                else
                    op = OP_NONE;
                if ($urandom_range(99) < 25)
                    key = {$urandom, $urandom};
                else
                    key = key_pool[$urandom_range(POOL_KEYS - 1)];
                send_command(op, key, ($urandom_range(99) < 90), 1'b0, NO_REPLY);
            end
        end
        s_valid <= 1'b0;

        // Drain: every owed result must arrive, then the output must stay
        // quiet for a while.
        traffic_mode = IDLE_OFF;
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (4 * QUEUE_DEPTH) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
